[sv/assert_macros.svh]
// Assertion macros shared by the checker files of this block.
// Needs signals named clk and rst in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Checked on every clock edge, reset included.
`define ASSERT_CLK_ALL(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/sitr_pkg.sv]
// Package for the signed integer to radix text unit: widths, codes,
// the alphabet byte lookup and the microcode ROM. No dependencies.
package sitr_pkg;

  // Input value width; a multiple of CHUNK_BITS between 8 and 32
  localparam int VALUE_BITS = 32;
  localparam int MAX_RADIX = 16;
  localparam int RADIX_BITS = $clog2(MAX_RADIX + 1);
  localparam int DIGIT_BITS = $clog2(MAX_RADIX);
  localparam int CHAR_BITS = 8;
  localparam int ALPHA_BITS = (MAX_RADIX / 2) * CHAR_BITS;

  // Digit store: at most one digit per value bit
  localparam int DIGIT_ADDR_BITS = $clog2(VALUE_BITS);
  localparam int TOTAL_BITS = DIGIT_ADDR_BITS + 1;

  // Divider retires this many quotient bits per cycle
  localparam int CHUNK_BITS = 8;
  localparam int NUM_CHUNKS = VALUE_BITS / CHUNK_BITS;
  localparam int CHUNK_CNT_BITS = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;

  // Configuration port
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS = 64;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DIGIT_COUNT   = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ALPHABET_LOW  = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ALPHABET_HIGH = 2'd2;

  localparam logic [RADIX_BITS-1:0] DIGIT_COUNT_RESET = 5'd10;
  localparam logic [ALPHA_BITS-1:0] ALPHABET_LOW_RESET = 64'd3978425819141910832;
  localparam logic [ALPHA_BITS-1:0] ALPHABET_HIGH_RESET = 64'd14641;

  localparam logic [CHAR_BITS-1:0] MINUS_CHAR = 8'h2D;
  localparam logic [CHAR_BITS-1:0] PLUS_CHAR  = 8'h2B;
  localparam logic [CHAR_BITS-1:0] NUL_CHAR   = 8'h00;

  // Divider control
  typedef struct packed {
    logic load;     // take a new magnitude, clear remainder and chunk count
    logic step;     // retire one chunk of quotient bits
    logic restart;  // begin the next division on the held quotient
  } div_ctl_t;

  // Microcode steps
  typedef enum logic [2:0] {
    ST_WAIT,
    ST_DIV,
    ST_STORE,
    ST_SIGN,
    ST_EMIT
  } step_t;

  // Jump conditions
  typedef enum logic [2:0] {
    C_ALWAYS,
    C_START,
    C_DIV_LAST,
    C_MORE,
    C_SIGN_GO,
    C_EMIT_DONE
  } cond_t;

  // One control word
  typedef struct packed {
    logic  ready;       // input channel open
    logic  load;        // capture value on a valid transaction
    logic  div;         // divider chunk step
    logic  store;       // write digit, restart divider
    logic  emit_sign;   // offer the minus sign
    logic  emit_digit;  // offer the next digit character
    logic  hold;        // fall-through stays on this step
    cond_t cond;
    step_t target;
  } ucw_t;

  // Microcode ROM
  function automatic ucw_t ucode(input step_t s);
    ucw_t w;
    w = '{ready: 1'b0, load: 1'b0, div: 1'b0, store: 1'b0, emit_sign: 1'b0,
          emit_digit: 1'b0, hold: 1'b0, cond: C_ALWAYS, target: ST_WAIT};
    unique case (s)
      ST_WAIT: begin
        w.ready = 1'b1; w.load = 1'b1; w.hold = 1'b1;
        w.cond = C_START; w.target = ST_DIV;
      end
      ST_DIV: begin
        w.div = 1'b1; w.hold = 1'b1;
        w.cond = C_DIV_LAST; w.target = ST_STORE;
      end
      ST_STORE: begin
        w.store = 1'b1;
        w.cond = C_MORE; w.target = ST_DIV;
      end
      ST_SIGN: begin
        w.emit_sign = 1'b1; w.hold = 1'b1;
        w.cond = C_SIGN_GO; w.target = ST_EMIT;
      end
      ST_EMIT: begin
        w.emit_digit = 1'b1; w.hold = 1'b1;
        w.cond = C_EMIT_DONE; w.target = ST_WAIT;
      end
      default: begin
        w.cond = C_ALWAYS; w.target = ST_WAIT;
      end
    endcase
    return w;
  endfunction

  // Alphabet byte for a digit index, character 0 in the lowest byte
  function automatic logic [CHAR_BITS-1:0] alpha_char(
    input logic [DIGIT_BITS-1:0] idx,
    input logic [ALPHA_BITS-1:0] lo,
    input logic [ALPHA_BITS-1:0] hi
  );
    logic [2*ALPHA_BITS-1:0] all;
    all = {hi, lo};
    return all[{idx, 3'b000} +: CHAR_BITS];
  endfunction

endpackage

[sv/sitr_alpha_check.sv]
// Alphabet validation: active radix and the validity flag.
// Depends on sitr_pkg.
module sitr_alpha_check import sitr_pkg::*; (
  input  logic [RADIX_BITS-1:0] digit_count,
  input  logic [ALPHA_BITS-1:0] alphabet_low,
  input  logic [ALPHA_BITS-1:0] alphabet_high,
  output logic [RADIX_BITS-1:0] radix,
  output logic                  ok
);

  logic [CHAR_BITS-1:0] chars [MAX_RADIX];
  logic [MAX_RADIX-1:0] in_use;
  logic [MAX_RADIX-1:0] bad;

  // Saturate the radix at the cap
  always_comb begin
    if (digit_count > RADIX_BITS'(MAX_RADIX)) radix = RADIX_BITS'(MAX_RADIX);
    else radix = digit_count;
  end

  // Per character: reserved byte, or a duplicate of a later active character
  always_comb begin
    for (int i = 0; i < MAX_RADIX; i++) begin
      chars[i]  = alpha_char(DIGIT_BITS'(i), alphabet_low, alphabet_high);
      in_use[i] = (RADIX_BITS'(i) < radix);
    end
    for (int i = 0; i < MAX_RADIX; i++) begin
      bad[i] = in_use[i] && (chars[i] == NUL_CHAR || chars[i] == PLUS_CHAR ||
                             chars[i] == MINUS_CHAR);
      for (int j = i + 1; j < MAX_RADIX; j++) begin
        if (in_use[i] && in_use[j] && chars[i] == chars[j]) bad[i] = 1'b1;
      end
    end
  end

  assign ok = (radix >= RADIX_BITS'(2)) && (bad == '0);

endmodule

[sv/sitr_divider.sv]
// Iterative divider by the radix, CHUNK_BITS quotient bits per cycle,
// with the quotient kept in place for the next digit. Depends on sitr_pkg.
module sitr_divider import sitr_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  div_ctl_t                  ctl,
  input  logic [RADIX_BITS-1:0]     radix,
  input  logic [VALUE_BITS-1:0]     mag,
  output logic [VALUE_BITS-1:0]     quot,
  output logic [DIGIT_BITS-1:0]     rem,
  output logic                      last_chunk
);

  logic [VALUE_BITS-1:0]     q;
  logic [VALUE_BITS-1:0]     q_next;
  logic [DIGIT_BITS-1:0]     r;
  logic [DIGIT_BITS-1:0]     r_next;
  logic [CHUNK_BITS-1:0]     qbits;
  logic [CHUNK_CNT_BITS-1:0] cnt;

  // Restoring long division over the top chunk; the remainder stays below radix
  always_comb begin
    logic [DIGIT_BITS:0] t;
    r_next = r;
    qbits  = '0;
    t      = '0;
    for (int k = 0; k < CHUNK_BITS; k++) begin
      t = {r_next, q[VALUE_BITS-1-k]};
      if (t >= (DIGIT_BITS+1)'(radix)) begin
        t = t - (DIGIT_BITS+1)'(radix);
        qbits[CHUNK_BITS-1-k] = 1'b1;
      end
      r_next = t[DIGIT_BITS-1:0];
    end
    q_next = (q << CHUNK_BITS) | VALUE_BITS'(qbits);
  end

  // Chunk counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (ctl.load || ctl.restart) begin
      cnt <= '0;
    end else if (ctl.step) begin
      cnt <= cnt + CHUNK_CNT_BITS'(1);
    end
  end

  // Dividend / quotient and partial remainder
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      q <= mag;
      r <= '0;
    end else if (ctl.restart) begin
      r <= '0;
    end else if (ctl.step) begin
      q <= q_next;
      r <= r_next;
    end
  end

  assign quot       = q;
  assign rem        = r;
  assign last_chunk = (cnt == CHUNK_CNT_BITS'(NUM_CHUNKS - 1));

endmodule

[sv/signed_int_to_radix_text_unit.sv]
// Signed integer to radix text: microcode sequencer, digit store, output register.
// Depends on sitr_pkg, sitr_alpha_check and sitr_divider.
//
// Usage:
//  - Input channel s_axis_*: one transaction carries one signed 32-bit value.
//  - Output channel m_axis_*: one transaction per character, most significant
//    first; a leading minus for negative values; tlast on the final digit.
//  - cfg_we/cfg_index/cfg_wdata write digit_count (0), alphabet_low (1) and
//    alphabet_high (2); write only while the unit is idle.
//  - With an invalid alphabet a value is taken and produces no characters.
// Sequence for each value:
//  - take the value, then per digit four 8-bit divide chunks and one store,
//    then the sign step, then the emit step that offers each character.
//  - A single chunk divider serves every digit in turn.
//  - s_axis_tready is high only while the sequencer waits for a value.
// Reset clears the sequencer, output valid and the radix registers to decimal.
// A stalled receiver holds the current character in the output register and
// the sequencer waits on that step; nothing is dropped.
module signed_int_to_radix_text_unit import sitr_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  // Input: value [31:0]
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [VALUE_BITS-1:0]     s_axis_tdata,
  // Output: out_char [7:0]
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [CHAR_BITS-1:0]      m_axis_tdata,
  output logic                      m_axis_tlast,
  // Configuration
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_wdata
);

  // Configuration registers
  logic [RADIX_BITS-1:0] digit_count;
  logic [ALPHA_BITS-1:0] alphabet_low;
  logic [ALPHA_BITS-1:0] alphabet_high;

  // Sequencer
  step_t upc;
  step_t upc_next;
  ucw_t  ucw;
  logic  cond_true;

  // Datapath
  logic [RADIX_BITS-1:0]      radix;
  logic                       alpha_ok;
  logic                       accept;
  logic                       start;
  logic                       neg;
  logic [TOTAL_BITS-1:0]      total;
  logic [DIGIT_BITS-1:0]      digit_store [VALUE_BITS];
  logic [DIGIT_ADDR_BITS-1:0] rd_addr;
  logic [VALUE_BITS-1:0]      raw;
  logic [VALUE_BITS-1:0]      mag;
  logic [VALUE_BITS-1:0]      quot;
  logic [DIGIT_BITS-1:0]      rem;
  logic                       last_chunk;
  logic                       more;
  div_ctl_t                   div_ctl;

  // Output register
  logic                 out_valid;
  logic [CHAR_BITS-1:0] out_char;
  logic                 out_last;
  logic                 slot_free;
  logic                 do_sign;
  logic                 do_digit;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      digit_count   <= DIGIT_COUNT_RESET;
      alphabet_low  <= ALPHABET_LOW_RESET;
      alphabet_high <= ALPHABET_HIGH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DIGIT_COUNT:   digit_count   <= cfg_wdata[RADIX_BITS-1:0];
        REG_ALPHABET_LOW:  alphabet_low  <= cfg_wdata[ALPHA_BITS-1:0];
        REG_ALPHABET_HIGH: alphabet_high <= cfg_wdata[ALPHA_BITS-1:0];
        default: ;
      endcase
    end
  end

  sitr_alpha_check u_alpha_check (
    .digit_count   (digit_count),
    .alphabet_low  (alphabet_low),
    .alphabet_high (alphabet_high),
    .radix         (radix),
    .ok            (alpha_ok)
  );

  // Control word decode and qualified actions
  always_comb begin
    ucw       = ucode(upc);
    accept    = s_axis_tvalid && ucw.ready;
    start     = ucw.load && accept && alpha_ok;
    slot_free = !out_valid || m_axis_tready;
    do_sign   = ucw.emit_sign && neg && slot_free;
    do_digit  = ucw.emit_digit && slot_free;
    more      = (quot != '0) && (total != TOTAL_BITS'(VALUE_BITS - 1));
    div_ctl   = '{load: start, step: ucw.div, restart: ucw.store};
  end

  // Jump condition select
  always_comb begin
    unique case (ucw.cond)
      C_ALWAYS:    cond_true = 1'b1;
      C_START:     cond_true = start;
      C_DIV_LAST:  cond_true = last_chunk;
      C_MORE:      cond_true = more;
      C_SIGN_GO:   cond_true = !neg || slot_free;
      C_EMIT_DONE: cond_true = slot_free && (total == TOTAL_BITS'(1));
      default:     cond_true = 1'b0;
    endcase
  end

  // Next step
  always_comb begin
    if (cond_true)     upc_next = ucw.target;
    else if (ucw.hold) upc_next = upc;
    else               upc_next = step_t'(upc + 3'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) upc <= ST_WAIT;
    else     upc <= upc_next;
  end

  // Sign and magnitude of the incoming value
  assign raw = s_axis_tdata[VALUE_BITS-1:0];
  assign mag = raw[VALUE_BITS-1] ? (VALUE_BITS'(0) - raw) : raw;

  sitr_divider u_divider (
    .clk        (clk),
    .rst        (rst),
    .ctl        (div_ctl),
    .radix      (radix),
    .mag        (mag),
    .quot       (quot),
    .rem        (rem),
    .last_chunk (last_chunk)
  );

  // Sign flag and digit count
  always_ff @(posedge clk) begin
    if (rst) begin
      neg   <= 1'b0;
      total <= '0;
    end else if (start) begin
      neg   <= raw[VALUE_BITS-1];
      total <= '0;
    end else if (ucw.store) begin
      total <= total + TOTAL_BITS'(1);
    end else if (do_digit) begin
      total <= total - TOTAL_BITS'(1);
    end
  end

  // Digit store, least significant digit first
  always_ff @(posedge clk) begin
    if (ucw.store) digit_store[total[DIGIT_ADDR_BITS-1:0]] <= rem;
  end

  assign rd_addr = DIGIT_ADDR_BITS'(total - TOTAL_BITS'(1));

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (do_sign || do_digit) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_sign) begin
      out_char <= MINUS_CHAR;
      out_last <= 1'b0;
    end else if (do_digit) begin
      out_char <= alpha_char(digit_store[rd_addr], alphabet_low, alphabet_high);
      out_last <= (total == TOTAL_BITS'(1));
    end
  end

  assign s_axis_tready = ucw.ready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_char;
  assign m_axis_tlast  = out_last;

endmodule

[sv/sitr_checker.sv]
// Port-level checker for signed_int_to_radix_text_unit, bound to the top level.
// Depends on sitr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sitr_checker import sitr_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic [VALUE_BITS-1:0] s_axis_tdata,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [CHAR_BITS-1:0]  m_axis_tdata,
  input logic                  m_axis_tlast
);

  logic               in_txn;
  logic               out_stall;
  logic               out_minus;
  logic               open_with_out;
  logic [CHAR_BITS:0] out_word;

  assign in_txn        = s_axis_tvalid && s_axis_tready;
  assign out_stall     = m_axis_tvalid && !m_axis_tready;
  assign out_minus     = m_axis_tvalid && (m_axis_tdata == MINUS_CHAR);
  assign open_with_out = s_axis_tready && m_axis_tvalid;
  assign out_word      = {m_axis_tlast, m_axis_tdata};

  // A stalled character holds
  `ASSERT_CLK(a_out_hold, out_stall |=> m_axis_tvalid && $stable(out_word), "stall not held")

  // Reset empties the output register
  `ASSERT_CLK_ALL(a_reset_empty, rst |=> !m_axis_tvalid, "output valid after reset")

  // A new value is only taken once the previous text has reached its end
  `ASSERT_CLK(a_wait_after_last, open_with_out |-> m_axis_tlast, "input open mid-text")

  // The minus sign always has digits after it
  `ASSERT_CLK(a_minus_not_last, out_minus |-> !m_axis_tlast, "minus marked last")

  // An accepted transaction carries a defined value
  `ASSERT_CLK(a_in_known, in_txn |-> !$isunknown(s_axis_tdata), "unknown input value")

endmodule

bind signed_int_to_radix_text_unit sitr_checker u_sitr_checker (.*);

[tb/testbench.sv]
// Self-checking testbench for signed_int_to_radix_text_unit: values in, text out.
// Depends on sitr_pkg and the unit's RTL; a local text predictor checks every character.
// Directed table first, then randomised settings phases with bursty input and a stalling sink.
module testbench;
  import sitr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_ITEMS = 500;
  // Longest value is 32 binary digits
  localparam int DRAIN_CYCLES = 250;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [CHAR_BITS-1:0] ch;
    logic                 last;
  } text_char_t;

  typedef enum logic {ROW_VALUE, ROW_SETTING} row_kind_t;

  typedef struct {
    row_kind_t                 kind;
    logic [CFG_INDEX_BITS-1:0] idx;
    logic [CFG_DATA_BITS-1:0]  data;
    logic [VALUE_BITS-1:0]     value;
    bit                        typed;
    string                     text;
  } script_row_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [VALUE_BITS-1:0]     s_axis_tdata = '0;   // value [31:0]
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [CHAR_BITS-1:0]      m_axis_tdata;        // out_char [7:0]
  logic                      m_axis_tlast;
  logic                      cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_wdata = '0;

  // Local copy of the unit's configuration
  logic [4:0]               radix_reg = DIGIT_COUNT_RESET;
  logic [ALPHA_BITS-1:0]    digits_low = ALPHABET_LOW_RESET;
  logic [ALPHA_BITS-1:0]    digits_high = ALPHABET_HIGH_RESET;

  text_char_t  pending_chars[$];
  script_row_t script[$];
  int          mismatch_count = 0;
  int          chars_checked = 0;
  int          values_sent = 0;
  int          cycle_count = 0;
  int          burst_left = 0;
  bit          hold_off_req = 1'b0;

  signed_int_to_radix_text_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [CHAR_BITS-1:0] digit_glyph(input int idx);
    if (idx < 8) return digits_low[idx*8 +: 8];
    return digits_high[(idx-8)*8 +: 8];
  endfunction

  function automatic int effective_radix();
    return (radix_reg > MAX_RADIX) ? MAX_RADIX : int'(radix_reg);
  endfunction

  // Radix of at least two, no NUL or sign characters, no repeats
  function automatic bit alphabet_usable(input int radix);
    logic [CHAR_BITS-1:0] c;
    if (radix < 2) return 1'b0;
    for (int i = 0; i < radix; i++) begin
      c = digit_glyph(i);
      if (c == NUL_CHAR || c == PLUS_CHAR || c == MINUS_CHAR) return 1'b0;
      for (int j = i + 1; j < radix; j++)
        if (digit_glyph(j) == c) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Expected characters of one accepted value, appended to pending_chars
  function automatic void format_value(input logic [VALUE_BITS-1:0] v);
    int                    radix;
    int                    n;
    logic [VALUE_BITS-1:0] mag;
    logic [3:0]            digits[32];
    radix = effective_radix();
    if (!alphabet_usable(radix)) return;
    // two's complement negate keeps the most negative value exact
    mag = v[VALUE_BITS-1] ? -v : v;
    n = 0;
    do begin
      digits[n] = 4'(mag % radix);
      mag = mag / radix;
      n++;
    end while (mag != 0 && n < 32);
    if (v[VALUE_BITS-1]) pending_chars.push_back('{ch: MINUS_CHAR, last: 1'b0});
    for (int k = n - 1; k >= 0; k--)
      pending_chars.push_back('{ch: digit_glyph(int'(digits[k])), last: (k == 0)});
  endfunction

  function automatic void queue_typed_text(input string s);
    for (int i = 0; i < s.len(); i++)
      pending_chars.push_back('{ch: s[i], last: (i == s.len() - 1)});
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what);
    $display("MISMATCH at cycle %0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    text_char_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      chars_checked++;
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected char %02h last %0b", m_axis_tdata, m_axis_tlast));
      end else begin
        want = pending_chars.pop_front();
        if (m_axis_tdata !== want.ch)
          report_mismatch($sformatf("char %02h, wanted %02h", m_axis_tdata, want.ch));
        if (m_axis_tlast !== want.last)
          report_mismatch($sformatf("tlast %0b, wanted %0b", m_axis_tlast, want.last));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles, %0d chars outstanding", cycle_count,
               pending_chars.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sink
  // Picks a new random stall mode whenever its span runs out; a request from the
  // stimulus side holds tready low for HOLD_OFF_CYCLES so the unit backs up.
  initial begin : sink
    int mode;
    int span;
    int hold;
    mode = 0;
    span = 0;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold = HOLD_OFF_CYCLES;
      end
      if (hold > 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else begin
        if (span == 0) begin
          mode = $urandom_range(0, 3);
          span = $urandom_range(10, 80);
        end
        span--;
        case (mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= 1'($urandom);
          2: m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready <= !m_axis_tready;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------- source side

  // One input transaction; bursts of random length with random gaps between
  task automatic send_value(input logic [VALUE_BITS-1:0] v);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
    end
    burst_left--;
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= v;
    do @(posedge clk); while (!s_axis_tready);
    values_sent++;
  endtask

  // Drop valid, wait for every expected char, then let a value with no output finish
  task automatic settle_idle();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_DIGIT_COUNT:   radix_reg = data[4:0];
      REG_ALPHABET_LOW:  digits_low = data;
      REG_ALPHABET_HIGH: digits_high = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random radix and alphabet; now and then the used part is spoilt
  task automatic apply_random_settings(output bit usable);
    logic [4:0]           cnt;
    logic [CHAR_BITS-1:0] glyphs[16];
    bit                   taken[256];
    logic [CHAR_BITS-1:0] c;
    logic [63:0]          lo;
    logic [63:0]          hi;
    int                   eff;
    int                   p;
    case ($urandom_range(0, 9))
      0: cnt = 5'($urandom_range(17, 31));
      1: cnt = 5'($urandom_range(0, 1));
      2: cnt = 5'd16;
      3: cnt = 5'd2;
      default: cnt = 5'($urandom_range(3, 15));
    endcase
    eff = (cnt > MAX_RADIX) ? MAX_RADIX : int'(cnt);
    foreach (taken[i]) taken[i] = 1'b0;
    for (int i = 0; i < 16; i++) begin
      if (i < eff) begin
        do c = 8'($urandom_range(1, 255));
        while (taken[c] || c == PLUS_CHAR || c == MINUS_CHAR);
        taken[c] = 1'b1;
      end else begin
        c = 8'($urandom);  // unused bytes: anything, signs and NUL included
      end
      glyphs[i] = c;
    end
    if (eff >= 2 && $urandom_range(0, 5) == 0) begin
      p = $urandom_range(0, eff - 1);
      case ($urandom_range(0, 3))
        0: glyphs[p] = NUL_CHAR;
        1: glyphs[p] = PLUS_CHAR;
        2: glyphs[p] = MINUS_CHAR;
        default: glyphs[p] = glyphs[(p + $urandom_range(1, eff - 1)) % eff];
      endcase
    end
    for (int i = 0; i < 8; i++) begin
      lo[i*8 +: 8] = glyphs[i];
      hi[i*8 +: 8] = glyphs[i+8];
    end
    write_reg(REG_DIGIT_COUNT, {$urandom, 27'($urandom), cnt});
    write_reg(REG_ALPHABET_LOW, lo);
    write_reg(REG_ALPHABET_HIGH, hi);
    if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, {$urandom, $urandom});
    usable = alphabet_usable(effective_radix());
  endtask

  function automatic logic [VALUE_BITS-1:0] random_value();
    logic [VALUE_BITS-1:0] v;
    case ($urandom_range(0, 5))
      0: v = 32'($urandom_range(0, 40));
      1: v = -32'($urandom_range(1, 40));
      2: begin
        case ($urandom_range(0, 4))
          0: v = 32'h8000_0000;
          1: v = 32'h7FFF_FFFF;
          2: v = 32'hFFFF_FFFF;
          3: v = 32'h0000_0001;
          default: v = '0;
        endcase
      end
      3: begin
        v = $urandom >> $urandom_range(0, 31);
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // ---------------------------------------------------------------- directed table

  function automatic void add_setting(input logic [CFG_INDEX_BITS-1:0] idx,
                                      input logic [CFG_DATA_BITS-1:0] data);
    script.push_back('{kind: ROW_SETTING, idx: idx, data: data, value: '0,
                       typed: 1'b0, text: ""});
  endfunction

  function automatic void add_value(input logic [VALUE_BITS-1:0] v);
    script.push_back('{kind: ROW_VALUE, idx: '0, data: '0, value: v,
                       typed: 1'b0, text: ""});
  endfunction

  function automatic void add_typed(input logic [VALUE_BITS-1:0] v, input string s);
    script.push_back('{kind: ROW_VALUE, idx: '0, data: '0, value: v,
                       typed: 1'b1, text: s});
  endfunction

  function automatic void build_script();
    // Reset alphabet holds '1' in byte 8 as well as byte 1: rejected, no text
    add_typed(32'd0, "");
    add_setting(REG_ALPHABET_HIGH, 64'h4645_4443_4241_3938);  // "89ABCDEF"
    add_typed(32'd0, "0");
    add_typed(32'hFFFF_FFFF, "-1");
    add_typed(32'h7FFF_FFFF, "2147483647");
    add_typed(32'h8000_0000, "-2147483648");
    add_setting(REG_DIGIT_COUNT, 64'd16);
    add_typed(32'd255, "FF");
    add_typed(32'h8000_0000, "-80000000");
    // count above the cap saturates to sixteen
    add_setting(REG_DIGIT_COUNT, 64'd31);
    add_typed(32'h0000_0ABC, "ABC");
    add_setting(REG_DIGIT_COUNT, 64'd2);
    add_value(32'h8000_0000);
    add_value(32'h7FFF_FFFF);
    // radix below two
    add_setting(REG_DIGIT_COUNT, 64'd1);
    add_typed(32'd5, "");
    add_setting(REG_DIGIT_COUNT, 64'd0);
    add_typed(32'd5, "");
    // base three; bytes past the radix hold signs and NUL and are ignored
    add_setting(REG_DIGIT_COUNT, 64'd3);
    add_setting(REG_ALPHABET_LOW, 64'h0000_2B2D_2D7A_7978);
    add_typed(32'd5, "yz");
    add_typed(-32'd9, "-yxx");
    // spoilt alphabets: plus, NUL, minus, repeated character
    add_setting(REG_ALPHABET_LOW, 64'h0000_0000_007A_2B78);
    add_typed(32'd7, "");
    add_setting(REG_ALPHABET_LOW, 64'h0000_0000_007A_0078);
    add_typed(32'd7, "");
    add_setting(REG_ALPHABET_LOW, 64'h0000_0000_002D_7978);
    add_typed(32'd7, "");
    add_setting(REG_ALPHABET_LOW, 64'h0000_0000_0078_7978);
    add_typed(32'd7, "");
    // extreme byte values as digits
    add_setting(REG_DIGIT_COUNT, 64'd4);
    add_setting(REG_ALPHABET_LOW, 64'hFFFF_FFFF_7F80_FF01);
    add_value(32'hFFFF_FFFF);
    add_value(32'h7FFF_FFFF);
    // index three is not a register: nothing may change
    add_setting(REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
    add_value(32'h0000_00C3);
  endfunction

  // ---------------------------------------------------------------- stimulus

  initial begin : stimulus
    int                    phase;
    int                    valid_items;
    int                    n;
    int                    held;
    bit                    usable;
    logic [VALUE_BITS-1:0] v;
    phase = 0;
    valid_items = 0;
    held = 0;
    build_script();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (script[r]) begin
      if (script[r].kind == ROW_SETTING) begin
        settle_idle();
        write_reg(script[r].idx, script[r].data);
      end else begin
        send_value(script[r].value);
        if (script[r].typed) queue_typed_text(script[r].text);
        else format_value(script[r].value);
      end
    end

    // Random settings phases; the first usable one and a few more get a long sink hold-off
    while (valid_items < RANDOM_ITEMS) begin
      settle_idle();
      apply_random_settings(usable);
      n = usable ? $urandom_range(15, 40) : $urandom_range(2, 5);
      for (int i = 0; i < n; i++) begin
        if (usable && i == 3 && (held == 0 || phase % 6 == 1)) begin
          hold_off_req = 1'b1;
          held++;
        end
        v = random_value();
        send_value(v);
        format_value(v);
        if (usable) valid_items++;
      end
      phase++;
    end

    settle_idle();
    if (pending_chars.size() != 0)
      report_mismatch($sformatf("%0d chars never arrived", pending_chars.size()));
    $display("Covered %0d values (directed table plus %0d random settings phases),",
             values_sent, phase);
    $display("%0d characters checked, %0d mismatches, %0d cycles.",
             chars_checked, mismatch_count, cycle_count);
    if (mismatch_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
